// File: hw/rtl/cccd_pkg.sv
// Shared types, codes and rule tables for the chain code corner detector.
`timescale 1ns / 1ps

package cccd_pkg;

    localparam int COORD_W  = 12;  // coordinate field width on the ports
    localparam int LEN_W    = 16;  // contour length / min length width
    localparam int THR_W    = 4;   // threshold register width
    localparam int FEAT_W   = 16;  // feature index width
    localparam int TYPE_W   = 3;   // corner type width
    localparam int CNT_BITS = 4;   // direction counters, holds WINDOW up to 15
    localparam int NDIR     = 4;
    localparam int NRULE    = 8;
    localparam int MAX_RES  = 4;   // results per input item
    localparam int CFG_W    = 16;  // config write data width

    // move codes held in the window cells
    typedef enum logic [2:0] {
        MV_NONE  = 3'd0,
        MV_RIGHT = 3'd1,
        MV_UP    = 3'd2,
        MV_LEFT  = 3'd3,
        MV_DOWN  = 3'd4
    } t_move;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_THRESHOLD  = 1'b0,
        CFG_MIN_LENGTH = 1'b1
    } t_cfg_idx;

    // direction index = move code - 1: right 0, up 1, left 2, down 3
    localparam logic [1:0] RULE_PRE [NRULE] = '{2'd2, 2'd1, 2'd0, 2'd3,
                                                2'd1, 2'd0, 2'd3, 2'd2};
    localparam logic [1:0] RULE_SUF [NRULE] = '{2'd1, 2'd0, 2'd3, 2'd2,
                                                2'd2, 2'd1, 2'd0, 2'd3};

    // window statistics handed to the rule stage
    typedef struct packed {
        logic                           first;
        logic                           armed;   // contour enabled and window full
        logic [NDIR-1:0][CNT_BITS-1:0]  before_cnt;
        logic [NDIR-1:0][CNT_BITS-1:0]  after_cnt;
        logic [COORD_W-1:0]             cx;
        logic [COORD_W-1:0]             cy;
    } t_eval_req;

endpackage

// File: hw/rtl/cccd_cell.sv
// One shift cell of the move window or point delay line.
`timescale 1ns / 1ps

module cccd_cell #(
    parameter int WIDTH = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  logic             i_clear,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_clear) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// File: hw/rtl/cccd_rules.sv
// Corner rule evaluation, type/feature tracking and the result burst register.
`timescale 1ns / 1ps

module cccd_rules (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  cccd_pkg::t_eval_req       i_req,
    input  logic [cccd_pkg::THR_W-1:0] i_threshold,
    output logic                      o_take,
    output logic                      o_tvalid,
    input  logic                      i_tready,
    output logic [39:0]               o_tdata,   // corner_x, corner_y, feature_index
    output logic [7:0]                o_tuser,   // corner_type, zero pad
    output logic                      o_tlast
);
    import cccd_pkg::*;

    logic [3:0]        r_last_type;  // 0 none, else rule + 1
    logic [FEAT_W-1:0] r_feat;
    logic [2:0]        r_cnt;

    logic [COORD_W-1:0] r_x    [MAX_RES];
    logic [COORD_W-1:0] r_y    [MAX_RES];
    logic [TYPE_W-1:0]  r_t    [MAX_RES];
    logic [FEAT_W-1:0]  r_fi   [MAX_RES];
    logic               r_last [MAX_RES];

    logic [3:0]        lt;
    logic [2:0]        k;
    logic [TYPE_W-1:0] res_t [MAX_RES];
    logic              can_load;
    logic              pop;

    // rules in order, each step sees the type left by the one before
    always_comb begin
        lt = r_last_type;
        k  = '0;
        for (int j = 0; j < MAX_RES; j++) res_t[j] = '0;
        for (int i = 0; i < NRULE; i++) begin
            if (i_req.armed && k < 3'd4 &&
                {1'b0, i_req.before_cnt[RULE_PRE[i]]} > {1'b0, i_threshold} &&
                {1'b0, i_req.after_cnt[RULE_SUF[i]]} > {1'b0, i_threshold} &&
                lt != 4'(i + 1)) begin
                res_t[k[1:0]] = TYPE_W'(i);
                lt = 4'(i + 1);
                k  = k + 3'd1;
            end
        end
    end

    assign pop      = o_tvalid && i_tready;
    assign can_load = (r_cnt == 3'd0) || (r_cnt == 3'd1 && i_tready);
    assign o_take   = i_valid && (k == 3'd0 || can_load);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_type <= '0;
            r_feat      <= '0;
            r_cnt       <= '0;
        end else begin
            if (o_take && i_req.first) begin
                r_last_type <= '0;
                r_feat      <= '0;
            end else if (o_take && k != 3'd0) begin
                r_last_type <= lt;
                r_feat      <= r_feat + FEAT_W'(k);
            end
            if (o_take && k != 3'd0) begin
                r_cnt <= k;
            end else if (pop) begin
                r_cnt <= r_cnt - 3'd1;
            end
        end
    end

    // burst slots: load on an accepted request that yields results, shift toward slot 0 on pop
    always_ff @(posedge i_clk) begin
        if (o_take && k != 3'd0) begin
            for (int j = 0; j < MAX_RES; j++) begin
                r_x[j]    <= i_req.cx;
                r_y[j]    <= i_req.cy;
                r_t[j]    <= res_t[j];
                r_fi[j]   <= r_feat + FEAT_W'(j);
                r_last[j] <= (3'(j) + 3'd1 == k);
            end
        end else if (pop) begin
            for (int j = 0; j < MAX_RES - 1; j++) begin
                r_x[j]    <= r_x[j+1];
                r_y[j]    <= r_y[j+1];
                r_t[j]    <= r_t[j+1];
                r_fi[j]   <= r_fi[j+1];
                r_last[j] <= r_last[j+1];
            end
        end
    end

    assign o_tvalid = (r_cnt != 3'd0);
    assign o_tdata  = {r_fi[0], r_y[0], r_x[0]};
    assign o_tuser  = {5'd0, r_t[0]};
    assign o_tlast  = r_last[0];

    a_last_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tvalid |-> (o_tlast == (r_cnt == 3'd1)))
        else $error("tlast does not mark the final result of a burst");

    a_index_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && r_cnt > 3'd1) |=> (r_fi[0] == $past(r_fi[0]) + FEAT_W'(1)))
        else $error("feature index skipped inside a burst");

    a_type_changes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > 3'd1) |-> (r_t[0] != r_t[1]))
        else $error("repeated corner type inside a burst");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= 3'd4))
        else $error("burst count above four");

endmodule

// File: hw/rtl/chain_code_corner_detector.sv
// Top level of the chain code corner detector: window cells, counts, rule stage.
`timescale 1ns / 1ps

// Usage
//   s_axis: one contour point per request. tdata = x_coord[11:0], y_coord[23:12],
//   contour_length[39:24]; tuser = first_point. Software pads each contour with
//   its last WINDOW points in front and first WINDOW points behind.
//   m_axis: one feature point per request. tdata = corner_x, corner_y,
//   feature_index; tuser = corner_type; tlast on the last result of an input.
//   Config: i_cfg_wen/i_cfg_idx/i_cfg_data, index 0 threshold, 1 min length;
//   write only while idle.
// Timing
//   A point is taken into the move window cells (2*WINDOW) and the point delay
//   cells (WINDOW+1); direction counts follow incrementally. The registered point
//   then goes to the rule stage, which evaluates all eight rules and loads up to
//   four results into the burst register, where the first result shows. Sustained
//   rate is one point per cycle while no stall holds it; an input that yields
//   results waits in the rule stage while an earlier burst still holds more than
//   its last result or is held by m_axis_tready, as it drains one per ready cycle.
// Reset
//   Synchronous, active low: threshold 3, min length 50, no contour armed.
// Stall
//   When m_axis_tready is low the burst holds; the rule stage, then s_axis_tready,
//   back up behind it. Nothing is lost.
module chain_code_corner_detector #(
    parameter int WINDOW     = 10,
    parameter int COORD_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // x_coord, y_coord, contour_length
    input  logic [7:0]  s_axis_tuser,   // first_point, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // corner_x, corner_y, feature_index
    output logic [7:0]  m_axis_tuser,   // corner_type, zero pad
    output logic        m_axis_tlast,
    input  logic        i_cfg_wen,
    input  logic [0:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import cccd_pkg::*;

    localparam int CW     = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam int TWO_W  = 2 * WINDOW;
    localparam int FILL_W = $clog2(TWO_W + 1);

    // configuration
    logic [THR_W-1:0] r_threshold;
    logic [LEN_W-1:0] r_min_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THR_W'(3);
            r_min_len   <= LEN_W'(50);
        end else if (i_cfg_wen) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_THRESHOLD:  r_threshold <= i_cfg_data[THR_W-1:0];
                CFG_MIN_LENGTH: r_min_len   <= i_cfg_data[LEN_W-1:0];
                default:        r_threshold <= r_threshold;
            endcase
        end
    end

    // input fields
    logic [CW-1:0]    in_x, in_y;
    logic             in_first;
    logic [LEN_W-1:0] in_len;
    logic             accept;
    logic             take;
    logic             r_eval_v;
    logic             r_eval_first;

    assign in_x     = s_axis_tdata[CW-1:0];
    assign in_y     = s_axis_tdata[COORD_W+CW-1:COORD_W];
    assign in_len   = s_axis_tdata[2*COORD_W+LEN_W-1:2*COORD_W];
    assign in_first = s_axis_tuser[0];

    assign s_axis_tready = !r_eval_v || take;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // move code against the previous point, no wrap at the range edge
    logic [CW-1:0] r_px, r_py;
    t_move         code_new;

    always_comb begin
        if ({1'b0, in_x} == {1'b0, r_px} + 1'b1 && in_y == r_py) begin
            code_new = MV_RIGHT;
        end else if (in_x == r_px && {1'b0, in_y} == {1'b0, r_py} + 1'b1) begin
            code_new = MV_UP;
        end else if ({1'b0, in_x} + 1'b1 == {1'b0, r_px} && in_y == r_py) begin
            code_new = MV_LEFT;
        end else if (in_x == r_px && {1'b0, in_y} + 1'b1 == {1'b0, r_py}) begin
            code_new = MV_DOWN;
        end else begin
            code_new = MV_NONE;
        end
    end

    // move window: index 0 oldest, new code enters at the top
    logic [2:0] w_q [TWO_W];

    for (genvar i = 0; i < TWO_W; i++) begin : g_move
        logic [2:0] d;
        if (i == TWO_W - 1) begin : g_top
            assign d = code_new;
        end else begin : g_mid
            assign d = w_q[i+1];
        end
        cccd_cell #(.WIDTH(3)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (accept && !in_first),
            .i_clear (accept && in_first),
            .i_d     (d),
            .o_q     (w_q[i])
        );
    end

    // point delay line, centre point at the far end
    logic [2*CW-1:0] p_q [WINDOW+1];

    for (genvar i = 0; i <= WINDOW; i++) begin : g_point
        logic [2*CW-1:0] d;
        if (i == 0) begin : g_head
            assign d = {in_y, in_x};
        end else begin : g_tail
            assign d = p_q[i-1];
        end
        cccd_cell #(.WIDTH(2*CW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (accept),
            .i_clear (1'b0),
            .i_d     (d),
            .o_q     (p_q[i])
        );
    end

    // incremental direction counts: oldest leaves before, middle crosses over
    logic [NDIR-1:0][CNT_BITS-1:0] r_before, r_after, n_before, n_after;
    logic [2:0]                    w_lo, w_mid;

    assign w_lo  = w_q[0];
    assign w_mid = w_q[WINDOW];

    always_comb begin
        for (int d = 0; d < NDIR; d++) begin
            n_before[d] = r_before[d] + CNT_BITS'(w_mid == 3'(d + 1))
                                      - CNT_BITS'(w_lo == 3'(d + 1));
            n_after[d]  = r_after[d] + CNT_BITS'(code_new == 3'(d + 1))
                                     - CNT_BITS'(w_mid == 3'(d + 1));
        end
    end

    logic [FILL_W-1:0] r_fill;
    logic              r_enabled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_before     <= '0;
            r_after      <= '0;
            r_fill       <= '0;
            r_enabled    <= 1'b0;
            r_px         <= '0;
            r_py         <= '0;
            r_eval_v     <= 1'b0;
            r_eval_first <= 1'b0;
        end else begin
            if (accept) begin
                r_px         <= in_x;
                r_py         <= in_y;
                r_eval_first <= in_first;
                if (in_first) begin
                    r_before  <= '0;
                    r_after   <= '0;
                    r_fill    <= '0;
                    r_enabled <= (in_len > r_min_len);
                end else begin
                    r_before <= n_before;
                    r_after  <= n_after;
                    if (r_fill != FILL_W'(TWO_W)) r_fill <= r_fill + 1'b1;
                end
            end
            if (accept) begin
                r_eval_v <= 1'b1;
            end else if (take) begin
                r_eval_v <= 1'b0;
            end
        end
    end

    // rule stage request
    t_eval_req req;

    assign req.first      = r_eval_first;
    assign req.armed      = r_enabled && (r_fill == FILL_W'(TWO_W));
    assign req.before_cnt = r_before;
    assign req.after_cnt  = r_after;
    assign req.cx         = COORD_W'(p_q[WINDOW][CW-1:0]);
    assign req.cy         = COORD_W'(p_q[WINDOW][2*CW-1:CW]);

    cccd_rules u_rules (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_eval_v),
        .i_req       (req),
        .i_threshold (r_threshold),
        .o_take      (take),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tuser     (m_axis_tuser),
        .o_tlast     (m_axis_tlast)
    );

endmodule

// File: test/chain_code_corner_detector_test.sv
// Testbench for the chain code corner detector: padded contours checked by a scoreboard.
`timescale 1ns / 1ps

module chain_code_corner_detector_test;
    import cccd_pkg::*;

    localparam int WIN          = 10;          // window half length of the instance
    localparam int SPAN         = 2 * WIN;     // moves held before a centre is judged
    localparam int CYCLE_LIMIT  = 200000;      // far above the slowest correct run
    localparam int DRAIN_CYCLES = 12;          // cells, rule stage and a burst of four
    localparam int LONG_HOLD    = 300;         // receiver hold-off that backs up the input
    localparam int COORD_MAX    = (1 << COORD_W) - 1;
    localparam int NSEG         = 4;

    // per segment register settings; thresholds 0 and 15, lengths 0 and max are in here
    localparam logic [THR_W-1:0] SEG_THR [NSEG]    = '{4'd0, 4'd2, 4'd1, 4'd15};
    localparam logic [LEN_W-1:0] SEG_MINLEN [NSEG] = '{16'd0, 16'd30, 16'd20, 16'hFFFF};
    localparam int               SEG_POINTS [NSEG] = '{20, 20, 20, 8};

    typedef enum int {
        SHAPE_CLEAN,     // whole padded rectangle
        SHAPE_CUT,       // padded rectangle stopped early
        SHAPE_OVERRUN,   // padded rectangle that keeps going past its end
        SHAPE_NOISE      // random walk and jumps, first point now and then
    } t_shape;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [TYPE_W-1:0]  kind;
        logic [FEAT_W-1:0]  index;
        logic               last;
    } t_corner;

    // Tracks the window the way the block should and holds the corners still due.
    class t_corner_scoreboard;
        logic [THR_W-1:0]   threshold;
        logic [LEN_W-1:0]   min_len;
        t_move              moves[SPAN];
        logic [COORD_W-1:0] held_x[WIN+1];
        logic [COORD_W-1:0] held_y[WIN+1];
        logic [COORD_W-1:0] prev_x;
        logic [COORD_W-1:0] prev_y;
        int                 fill;
        int                 last_kind;      // 0 none, else 1 + rule
        logic [FEAT_W-1:0]  feat_count;
        bit                 armed;
        t_corner            due_q[$];
        int                 mismatches;

        function new();
            threshold  = 4'd3;
            min_len    = 16'd50;
            foreach (moves[i]) moves[i] = MV_NONE;
            foreach (held_x[i]) begin
                held_x[i] = '0;
                held_y[i] = '0;
            end
            prev_x     = '0;
            prev_y     = '0;
            fill       = 0;
            last_kind  = 0;
            feat_count = '0;
            armed      = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_THRESHOLD:  threshold = value[THR_W-1:0];
                CFG_MIN_LENGTH: min_len   = value[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        // unit steps only, no wrap at the coordinate edge
        function t_move step_move(int px, int py, int x, int y);
            if (x == px + 1 && y == py) return MV_RIGHT;
            if (x == px && y == py + 1) return MV_UP;
            if (x + 1 == px && y == py) return MV_LEFT;
            if (x == px && y + 1 == py) return MV_DOWN;
            return MV_NONE;
        endfunction

        // direction index: right 0, up 1, left 2, down 3
        function void rule_dirs(int rule, output int before_dir, output int after_dir);
            case (rule)
                0: begin before_dir = 2; after_dir = 1; end   // left then up
                1: begin before_dir = 1; after_dir = 0; end   // up then right
                2: begin before_dir = 0; after_dir = 3; end   // right then down
                3: begin before_dir = 3; after_dir = 2; end   // down then left
                4: begin before_dir = 1; after_dir = 2; end   // up then left
                5: begin before_dir = 0; after_dir = 1; end   // right then up
                6: begin before_dir = 3; after_dir = 0; end   // down then right
                default: begin before_dir = 2; after_dir = 3; end  // left then down
            endcase
        endfunction

        function void note_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, bit first,
                                 logic [LEN_W-1:0] len);
            int      before_n[NDIR];
            int      after_n[NDIR];
            int      bdir;
            int      adir;
            t_corner c;
            t_corner burst[$];
            if (first) begin
                foreach (moves[i]) moves[i] = MV_NONE;
                fill       = 0;
                last_kind  = 0;
                feat_count = '0;
                armed      = (len > min_len);
            end else begin
                for (int i = 0; i < SPAN - 1; i++) moves[i] = moves[i+1];
                moves[SPAN-1] = step_move(prev_x, prev_y, x, y);
                if (fill < SPAN) fill++;
            end
            for (int i = WIN; i > 0; i--) begin
                held_x[i] = held_x[i-1];
                held_y[i] = held_y[i-1];
            end
            held_x[0] = x;
            held_y[0] = y;
            prev_x    = x;
            prev_y    = y;
            if (!armed || fill < SPAN) return;

            foreach (before_n[i]) begin
                before_n[i] = 0;
                after_n[i]  = 0;
            end
            for (int i = 0; i < SPAN; i++) begin
                if (moves[i] != MV_NONE) begin
                    if (i < WIN) before_n[int'(moves[i]) - 1]++;
                    else after_n[int'(moves[i]) - 1]++;
                end
            end
            // rules in order, a repeat of the last type is skipped, at most four per point
            for (int r = 0; r < NRULE && burst.size() < MAX_RES; r++) begin
                rule_dirs(r, bdir, adir);
                if (before_n[bdir] > int'(threshold) && after_n[adir] > int'(threshold) &&
                    last_kind != r + 1) begin
                    c.x     = held_x[WIN];
                    c.y     = held_y[WIN];
                    c.kind  = r[TYPE_W-1:0];
                    c.index = feat_count;
                    c.last  = 1'b0;
                    burst   = {burst, c};
                    feat_count++;
                    last_kind = r + 1;
                end
            end
            if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
            foreach (burst[i]) due_q = {due_q, burst[i]};
        endfunction

        function void compare(string field, logic [FEAT_W-1:0] want, logic [FEAT_W-1:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("corner mismatch on %s: expected %0d, got %0d", field, want, got);
            end
        endfunction

        function void check_result(t_corner got);
            t_corner want;
            if (due_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected corner: x %0d y %0d type %0d index %0d last %0b",
                             got.x, got.y, got.kind, got.index, got.last);
                return;
            end
            want = due_q.pop_front();
            compare("corner_x", FEAT_W'(want.x), FEAT_W'(got.x));
            compare("corner_y", FEAT_W'(want.y), FEAT_W'(got.y));
            compare("corner_type", FEAT_W'(want.kind), FEAT_W'(got.kind));
            compare("feature_index", want.index, got.index);
            compare("last_of_run", FEAT_W'(want.last), FEAT_W'(got.last));
        endfunction
    endclass

    // block ports, all inputs known from time zero
    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                s_axis_tvalid  = 1'b0;
    logic                s_axis_tready;
    logic [39:0]         s_axis_tdata   = '0;   // x_coord, y_coord, contour_length
    logic [7:0]          s_axis_tuser   = '0;   // first_point, zero pad
    logic                m_axis_tvalid;
    logic                m_axis_tready  = 1'b0;
    logic [39:0]         m_axis_tdata;          // corner_x, corner_y, feature_index
    logic [7:0]          m_axis_tuser;          // corner_type, zero pad
    logic                m_axis_tlast;
    logic                i_cfg_wen      = 1'b0;
    logic [0:0]          i_cfg_idx      = '0;
    logic [CFG_W-1:0]    i_cfg_data     = '0;

    t_corner_scoreboard  sb = new();
    int                  send_idle_pct  = 13;
    int                  recv_idle_pct  = 82;
    int                  hold_request   = 0;    // set by stimulus, taken by the receiver
    int                  points_sent    = 0;
    int                  cycles         = 0;

    chain_code_corner_detector #(
        .WINDOW     (WIN),
        .COORD_BITS (COORD_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin : clock_gen
        forever #1 i_clk = ~i_clk;
    end

    // Run limit; only reached when the block hangs or drops a request.
    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("chain_code_corner_detector_test: FAIL");
        $finish;
    end

    // Receiver: checks every accepted corner, then picks tready for the next edge.
    // A long hold-off counts down here while the sender keeps offering points.
    initial begin : receiver
        t_corner got;
        int      hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got.x     = m_axis_tdata[COORD_W-1:0];
                got.y     = m_axis_tdata[2*COORD_W-1:COORD_W];
                got.index = m_axis_tdata[2*COORD_W+FEAT_W-1:2*COORD_W];
                got.kind  = m_axis_tuser[TYPE_W-1:0];
                got.last  = m_axis_tlast;
                sb.check_result(got);
            end
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // One point request; returns at the edge where it was accepted.
    task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input bit first, input logic [LEN_W-1:0] len);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {len, y, x};
        s_axis_tuser  <= {7'd0, first};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_point(x, y, first, len);
        points_sent++;
    endtask

    // Drop tvalid, wait until every corner is in, then let the pipe drain.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Both registers, back to back; only called while idle.
    task automatic write_config(input logic [THR_W-1:0] thr, input logic [LEN_W-1:0] min_len);
        i_cfg_wen  <= 1'b1;
        i_cfg_idx  <= CFG_THRESHOLD;
        i_cfg_data <= {{(CFG_W-THR_W){1'b0}}, thr};
        @(posedge i_clk);
        sb.write_reg(CFG_THRESHOLD, {{(CFG_W-THR_W){1'b0}}, thr});
        i_cfg_idx  <= CFG_MIN_LENGTH;
        i_cfg_data <= min_len;
        @(posedge i_clk);
        sb.write_reg(CFG_MIN_LENGTH, min_len);
        i_cfg_wen  <= 1'b0;
    endtask

    function automatic int pick_origin(int size);
        case ($urandom_range(0, 5))
            0:       return 0;                        // touches the low edge
            1:       return COORD_MAX - size;         // touches the high edge
            default: return $urandom_range(0, COORD_MAX - size);
        endcase
    endfunction

    // One contour: a rectangle walked either way from a random start, padded
    // with WIN points on each side, or a noise burst.
    task automatic send_contour(input t_shape shape);
        logic [COORD_W-1:0] px[$];
        logic [COORD_W-1:0] py[$];
        logic [LEN_W-1:0]   len;
        int                 w;
        int                 h;
        int                 ox;
        int                 oy;
        int                 n;
        int                 start;
        int                 dir;
        int                 stop;
        int                 j;
        int                 wx;
        int                 wy;
        if (shape == SHAPE_NOISE) begin
            wx = $urandom_range(0, COORD_MAX);
            wy = $urandom_range(0, COORD_MAX);
            repeat ($urandom_range(4, 12)) begin
                if ($urandom_range(0, 3) == 0) begin
                    wx = $urandom_range(0, COORD_MAX);
                    wy = $urandom_range(0, COORD_MAX);
                end else begin
                    wx += int'($urandom_range(0, 2)) - 1;
                    wy += int'($urandom_range(0, 2)) - 1;
                    if (wx < 0) wx = 0;
                    if (wx > COORD_MAX) wx = COORD_MAX;
                    if (wy < 0) wy = 0;
                    if (wy > COORD_MAX) wy = COORD_MAX;
                end
                send_point(COORD_W'(wx), COORD_W'(wy), $urandom_range(0, 7) == 0,
                           LEN_W'($urandom_range(0, 65535)));
            end
            return;
        end

        w  = $urandom_range(2, 7);
        h  = $urandom_range(2, 7);
        ox = pick_origin(w);
        oy = pick_origin(h);
        for (int i = 0; i < w; i++) begin
            px = {px, COORD_W'(ox + i)};
            py = {py, COORD_W'(oy)};
        end
        for (int i = 0; i < h; i++) begin
            px = {px, COORD_W'(ox + w)};
            py = {py, COORD_W'(oy + i)};
        end
        for (int i = 0; i < w; i++) begin
            px = {px, COORD_W'(ox + w - i)};
            py = {py, COORD_W'(oy + h)};
        end
        for (int i = 0; i < h; i++) begin
            px = {px, COORD_W'(ox)};
            py = {py, COORD_W'(oy + h - i)};
        end
        n = px.size();

        // one displaced point breaks two moves
        if ($urandom_range(0, 2) == 0) begin
            j = $urandom_range(0, n - 1);
            px[j] = (px[j] < COORD_MAX) ? COORD_W'(px[j] + 1) : COORD_W'(px[j] - 1);
            py[j] = (py[j] < COORD_MAX) ? COORD_W'(py[j] + 1) : COORD_W'(py[j] - 1);
        end

        // mostly above the noise filter, now and then at or below it
        if ($urandom_range(0, 4) != 0 && sb.min_len != 16'hFFFF)
            len = LEN_W'($urandom_range(int'(sb.min_len) + 1, 65535));
        else
            len = LEN_W'($urandom_range(0, int'(sb.min_len)));

        start = $urandom_range(0, n - 1);
        dir   = ($urandom_range(0, 1) == 0) ? 1 : -1;
        case (shape)
            SHAPE_CUT:     stop = $urandom_range(1, n + SPAN - 1);
            SHAPE_OVERRUN: stop = n + SPAN + $urandom_range(1, 6);
            default:       stop = n + SPAN;
        endcase
        for (int k = 0; k < stop; k++) begin
            j = ((start + dir * (k - WIN)) % n + n) % n;
            send_point(px[j], py[j], k == 0, (k == 0) ? len : LEN_W'($urandom_range(0, 65535)));
        end
    endtask

    function automatic t_shape pick_shape();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return SHAPE_CLEAN;
        if (r < 80) return SHAPE_CUT;
        if (r < 90) return SHAPE_OVERRUN;
        return SHAPE_NOISE;
    endfunction

    initial begin : stimulus
        int seg_start;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings (threshold 3, min length 50), slow receiver.
        send_point(12'd4095, 12'd4095, 1'b0, 16'hFFFF);  // no first point since reset
        send_point(12'd0,    12'd0,    1'b0, 16'd0);
        send_point(12'd4095, 12'd0,    1'b0, 16'd0);
        send_point(12'd4095, 12'd4095, 1'b1, 16'd50);     // length equal to min: filtered
        send_point(12'd0,    12'd4095, 1'b0, 16'd0);      // 4095 to 0 is no move
        send_point(12'd0,    12'd4094, 1'b0, 16'd0);
        send_point(12'd4094, 12'd4095, 1'b1, 16'd51);     // just above min: armed
        send_point(12'd4095, 12'd4095, 1'b0, 16'd0);      // right
        send_point(12'd4095, 12'd4094, 1'b0, 16'd0);      // down
        send_point(12'd4094, 12'd4094, 1'b0, 16'd0);      // left
        send_point(12'd4094, 12'd4095, 1'b0, 16'd0);      // up
        send_point(12'd4095, 12'd0,    1'b0, 16'hFFFF);
        send_point(12'd0,    12'd0,    1'b1, 16'd0);
        send_point(12'd0,    12'd0,    1'b1, 16'hFFFF);   // first point twice in a row
        send_point(12'd1,    12'd1,    1'b0, 16'd0);      // diagonal
        send_point(12'd1,    12'd0,    1'b0, 16'd0);      // down

        // Random segments: slow receiver, slow sender, then two at full speed.
        for (int seg = 0; seg < NSEG; seg++) begin
            wait_idle();
            write_config(SEG_THR[seg], SEG_MINLEN[seg]);
            case (seg)
                0:       begin send_idle_pct = 13; recv_idle_pct = 82; end
                1:       begin send_idle_pct = 82; recv_idle_pct = 13; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            if (seg == 2) hold_request = LONG_HOLD;
            seg_start = points_sent;
            while (points_sent - seg_start < SEG_POINTS[seg]) begin
                if (seg == 2) send_contour(SHAPE_CLEAN);      // low threshold fills the burst
                else if (seg == 3) send_contour(SHAPE_NOISE);
                else send_contour(pick_shape());
            end
        end

        wait_idle();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("chain_code_corner_detector_test: PASS");
        end else begin
            $display("chain_code_corner_detector_test: FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/cccd_pkg.sv
hw/rtl/cccd_cell.sv
hw/rtl/cccd_rules.sv
hw/rtl/chain_code_corner_detector.sv
test/chain_code_corner_detector_test.sv
